### rtl/ssp_pkg.sv
// shared types and constants for the sprite screen projection block
// no dependencies
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int SCREEN_COLUMNS = 640;
  localparam int SCREEN_ROWS    = 480;
  localparam int HALF_COLS      = SCREEN_COLUMNS / 2;
  localparam int HALF_ROWS      = SCREEN_ROWS / 2;

  // divider geometry: quotient bits, numerator and divisor widths
  localparam int DIV_QW  = 16;
  localparam int DIV_NW  = 56;
  localparam int DIV_DW  = 40;
  localparam int DIV_LAT = DIV_QW + 1;

  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = 5;
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [2:0] {
    CfgPlayerPosX   = 3'd0,
    CfgPlayerPosY   = 3'd1,
    CfgViewDirX     = 3'd2,
    CfgViewDirY     = 3'd3,
    CfgCameraPlaneX = 3'd4,
    CfgCameraPlaneY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] sprite_pos_x;
    logic [15:0] sprite_pos_y;
    logic [2:0]  sprite_texture;
  } in_item_t;

  typedef struct packed {
    logic               in_front;
    logic signed [15:0] depth;
    logic signed [15:0] centre_column;
    logic [11:0]        sprite_size;
    logic [9:0]         first_column;
    logic [9:0]         last_column;
    logic [8:0]         first_row;
    logic [8:0]         last_row;
    logic [2:0]         texture_out;
  } out_item_t;

  // classification of one sprite, travels beside the dividers
  typedef struct packed {
    logic       valid;
    logic [2:0] texture;
    logic       det_zero;
    logic       m_zero;
    logic       n_neg;
    logic       n_zero;
    logic       in_front;
    logic       depth_neg;
    logic       centre_neg;
  } flags_t;

endpackage

### rtl/ssp_front.sv
// front end: config registers, camera transform and divider operands
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_front import ssp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  in_item_t          in_data_i,
  output logic [DIV_NW-1:0] num_depth_o,
  output logic [DIV_DW-1:0] den_depth_o,
  output logic [DIV_NW-1:0] num_centre_o,
  output logic [DIV_DW-1:0] den_centre_o,
  output logic [DIV_NW-1:0] num_size_o,
  output logic [DIV_DW-1:0] den_size_o,
  output flags_t            flags_o
);

  logic [15:0] pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, pl_x_q, pl_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      dir_x_q <= 16'shC000;
      dir_y_q <= '0;
      pl_x_q  <= '0;
      pl_y_q  <= 16'sd10813;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPlayerPosX:   pos_x_q <= cfg_data_i;
        CfgPlayerPosY:   pos_y_q <= cfg_data_i;
        CfgViewDirX:     dir_x_q <= cfg_data_i;
        CfgViewDirY:     dir_y_q <= cfg_data_i;
        CfgCameraPlaneX: pl_x_q  <= cfg_data_i;
        CfgCameraPlaneY: pl_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: offsets from the player
  logic               v1_q;
  logic [2:0]         tex1_q;
  logic signed [16:0] sx_q, sy_q;

  // stage 2: products
  logic               v2_q;
  logic [2:0]         tex2_q;
  logic signed [32:0] dysx_q, dxsy_q, pysx_q, pxsy_q;
  logic signed [32:0] pxdy_q, dxpy_q;

  // stage 3: n, m and determinant
  logic               v3_q;
  logic [2:0]         tex3_q;
  logic signed [33:0] n_q, m_q, det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tex1_q <= in_data_i.sprite_texture;
    sx_q   <= $signed({1'b0, in_data_i.sprite_pos_x}) - $signed({1'b0, pos_x_q});
    sy_q   <= $signed({1'b0, in_data_i.sprite_pos_y}) - $signed({1'b0, pos_y_q});
    tex2_q <= tex1_q;
    dysx_q <= 33'(dir_y_q * sx_q);
    dxsy_q <= 33'(dir_x_q * sy_q);
    pysx_q <= 33'(pl_y_q * sx_q);
    pxsy_q <= 33'(pl_x_q * sy_q);
    pxdy_q <= 33'(pl_x_q * dir_y_q);
    dxpy_q <= 33'(dir_x_q * pl_y_q);
    tex3_q <= tex2_q;
    n_q    <= 34'(dysx_q) - 34'(dxsy_q);
    m_q    <= 34'(pxsy_q) - 34'(pysx_q);
    det_q  <= 34'(pxdy_q) - 34'(dxpy_q);
  end

  // stage 4: magnitudes, signs and operands
  logic signed [34:0] mn;
  logic [34:0]        abs_m, abs_det, abs_mn;
  flags_t             flags_d;

  always_comb begin
    mn      = 35'(m_q) + 35'(n_q);
    abs_m   = m_q[33]   ? 35'(-35'(m_q))   : 35'(m_q);
    abs_det = det_q[33] ? 35'(-35'(det_q)) : 35'(det_q);
    abs_mn  = mn[34]    ? 35'(-mn)         : 35'(mn);
    flags_d.valid      = v3_q;
    flags_d.texture    = tex3_q;
    flags_d.det_zero   = (det_q == '0);
    flags_d.m_zero     = (m_q == '0);
    flags_d.n_neg      = n_q[33];
    flags_d.n_zero     = (n_q == '0);
    flags_d.in_front   = (det_q != '0) && (m_q != '0) && (m_q[33] == det_q[33]);
    flags_d.depth_neg  = m_q[33] ^ det_q[33];
    flags_d.centre_neg = mn[34] ^ m_q[33];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_o <= '0;
    end else begin
      flags_o <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_depth_o  <= DIV_NW'(abs_m) << 14;
    den_depth_o  <= DIV_DW'(abs_det);
    num_centre_o <= DIV_NW'(abs_mn) * DIV_NW'(HALF_COLS);
    den_centre_o <= DIV_DW'(abs_m);
    num_size_o   <= DIV_NW'(abs_det) * DIV_NW'(SCREEN_ROWS);
    den_size_o   <= DIV_DW'(abs_m) << 6;
  end

endmodule

### rtl/ssp_div.sv
// pipelined restoring divider, one quotient bit per stage, overflow flag
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_div import ssp_pkg::*; (
  input  logic              clk_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quot_o,
  output logic              ovf_o
);

  logic [DIV_NW-1:0] rem_q  [DIV_QW+1];
  logic [DIV_DW-1:0] den_q  [DIV_QW+1];
  logic [DIV_QW-1:0] quot_q [DIV_QW+1];
  logic              ovf_q  [DIV_QW+1];

  // quotient would not fit in DIV_QW bits
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i;
    den_q[0]  <= den_i;
    quot_q[0] <= '0;
    ovf_q[0]  <= (num_i >= (DIV_NW'(den_i) << DIV_QW));
  end

  for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
    localparam int Bit = DIV_QW - 1 - k;
    logic [DIV_NW-1:0] trial;
    logic              take;
    assign trial = DIV_NW'(den_q[k]) << Bit;
    assign take  = (rem_q[k] >= trial);
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= take ? rem_q[k] - trial : rem_q[k];
      den_q[k+1]  <= den_q[k];
      quot_q[k+1] <= quot_q[k] | (take ? (DIV_QW'(1) << Bit) : '0);
      ovf_q[k+1]  <= ovf_q[k];
    end
  end

  assign quot_o = quot_q[DIV_QW];
  assign ovf_o  = ovf_q[DIV_QW];

endmodule

### rtl/ssp_back.sv
// back end: saturation, special cases and screen clamping of the rectangle
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_back import ssp_pkg::*; (
  input  flags_t            flags_i,
  input  logic [DIV_QW-1:0] q_depth_i,
  input  logic              ovf_depth_i,
  input  logic [DIV_QW-1:0] q_centre_i,
  input  logic              ovf_centre_i,
  input  logic [DIV_QW-1:0] q_size_i,
  input  logic              ovf_size_i,
  output out_item_t         res_o
);

  function automatic logic signed [15:0] sat16(logic neg, logic ovf, logic [DIV_QW-1:0] q);
    logic signed [16:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (ovf) begin
      sat16 = neg ? 16'sh8000 : 16'sh7FFF;
    end else if (v > 17'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  logic signed [15:0] depth, centre;
  logic [11:0]        size;
  logic [10:0]        half;
  logic signed [17:0] col_lo, col_hi;
  logic signed [13:0] row_lo, row_hi;

  always_comb begin
    depth  = '0;
    centre = 16'(HALF_COLS);
    size   = '0;
    if (!flags_i.det_zero) begin
      if (flags_i.m_zero) begin
        size = 12'hFFF;
        if (flags_i.n_neg) begin
          centre = 16'sh8000;
        end else if (!flags_i.n_zero) begin
          centre = 16'sh7FFF;
        end
      end else begin
        depth  = sat16(flags_i.depth_neg, ovf_depth_i, q_depth_i);
        centre = sat16(flags_i.centre_neg, ovf_centre_i, q_centre_i);
        size   = (ovf_size_i || q_size_i > DIV_QW'(4095)) ? 12'hFFF : q_size_i[11:0];
      end
    end
    half   = size[11:1];
    col_lo = 18'(centre) - $signed({7'b0, half});
    col_hi = 18'(centre) + $signed({7'b0, half});
    row_lo = 14'(HALF_ROWS) - $signed({3'b0, half});
    row_hi = 14'(HALF_ROWS) + $signed({3'b0, half});

    res_o.in_front      = flags_i.in_front;
    res_o.depth         = depth;
    res_o.centre_column = centre;
    res_o.sprite_size   = size;
    res_o.texture_out   = flags_i.texture;
    res_o.first_column  = col_lo < 0 ? '0 :
                          col_lo > 18'(SCREEN_COLUMNS - 1) ?
                          10'(SCREEN_COLUMNS - 1) : col_lo[9:0];
    res_o.last_column   = col_hi < 0 ? '0 :
                          col_hi > 18'(SCREEN_COLUMNS - 1) ?
                          10'(SCREEN_COLUMNS - 1) : col_hi[9:0];
    res_o.first_row     = row_lo < 0 ? '0 :
                          row_lo > 14'(SCREEN_ROWS - 1) ? 9'(SCREEN_ROWS - 1) : row_lo[8:0];
    res_o.last_row      = row_hi < 0 ? '0 :
                          row_hi > 14'(SCREEN_ROWS - 1) ? 9'(SCREEN_ROWS - 1) : row_hi[8:0];
  end

endmodule

### rtl/ssp_fifo.sv
// result queue between the pipeline and the consumer
// depends on ssp_pkg
`timescale 1ns / 1ps

module ssp_fifo import ssp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  out_item_t          wr_data_i,
  input  logic               rd_i,
  output out_item_t          rd_data_o,
  output logic               empty_o,
  output logic [FIFO_CW-1:0] count_o
);

  out_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FIFO_CW'(wr_i) - FIFO_CW'(rd_i);
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;

endmodule

### rtl/sprite_screen_projection_top.sv
// a sprite passes the front-end stages, the dividers, then the result queue
// throughput: one sprite per cycle while full is low, carried by the pipelined dividers
// the 32-entry result queue reserves a slot per sprite in flight, so full rises
// only when the consumer falls behind
// reset: asynchronous active low, camera registers return to their defaults, queue empties
`timescale 1ns / 1ps

module sprite_screen_projection_top import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sprite input side
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data_o,
  // camera config writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic               in_xfer, pop_xfer;
  logic [DIV_NW-1:0]  num_depth, num_centre, num_size;
  logic [DIV_DW-1:0]  den_depth, den_centre, den_size;
  logic [DIV_QW-1:0]  q_depth, q_centre, q_size;
  logic               ovf_depth, ovf_centre, ovf_size;
  flags_t             front_flags;
  flags_t             side_q [DIV_LAT];
  out_item_t          res;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW-1:0] inflight_q;
  logic [FIFO_CW:0]   reserved;

  // config is always taken
  assign cfg_ready_o = 1'b1;

  // every sprite in flight owns a queue slot
  assign reserved = (FIFO_CW+1)'(inflight_q) + (FIFO_CW+1)'(fifo_count);
  assign full     = (reserved >= (FIFO_CW+1)'(FIFO_DEPTH));
  assign in_xfer  = push && !full;
  assign pop_xfer = pop && !empty;

  ssp_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i   (in_xfer),
    .in_data_i,
    .num_depth_o  (num_depth),
    .den_depth_o  (den_depth),
    .num_centre_o (num_centre),
    .den_centre_o (den_centre),
    .num_size_o   (num_size),
    .den_size_o   (den_size),
    .flags_o      (front_flags)
  );

  // three dividers run in lockstep
  ssp_div u_div_depth (
    .clk_i, .num_i(num_depth), .den_i(den_depth), .quot_o(q_depth), .ovf_o(ovf_depth)
  );
  ssp_div u_div_centre (
    .clk_i, .num_i(num_centre), .den_i(den_centre), .quot_o(q_centre), .ovf_o(ovf_centre)
  );
  ssp_div u_div_size (
    .clk_i, .num_i(num_size), .den_i(den_size), .quot_o(q_size), .ovf_o(ovf_size)
  );

  // classification flags delayed to match the divider latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= front_flags;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  ssp_back u_back (
    .flags_i      (side_q[DIV_LAT-1]),
    .q_depth_i    (q_depth),
    .ovf_depth_i  (ovf_depth),
    .q_centre_i   (q_centre),
    .ovf_centre_i (ovf_centre),
    .q_size_i     (q_size),
    .ovf_size_i   (ovf_size),
    .res_o        (res)
  );

  // sprites accepted but not yet in the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + FIFO_CW'(in_xfer) - FIFO_CW'(side_q[DIV_LAT-1].valid);
    end
  end

  ssp_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i      (side_q[DIV_LAT-1].valid),
    .wr_data_i (res),
    .rd_i      (pop_xfer),
    .rd_data_o (out_data_o),
    .empty_o   (empty),
    .count_o   (fifo_count)
  );

endmodule

### tb/tb_sprite_screen_projection_top.sv
// self-checking bench for the sprite screen projection block
// depends on ssp_pkg and sprite_screen_projection_top
`timescale 1ns / 1ps

module tb_sprite_screen_projection_top;
  import ssp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push, full, empty, pop;
  in_item_t    in_data_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  sprite_screen_projection_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // camera copy kept by the bench, updated on each config transfer
  logic [15:0] cam_pos_x, cam_pos_y, cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;

  out_item_t   projections_due[$];
  int unsigned mismatches;
  bit          no_idle;  // set during stretches where neither side idles

  // one directed row: player position to use, the sprite, optional typed result
  typedef struct {
    logic [15:0] player_x;
    logic [15:0] player_y;
    in_item_t    sprite;
    bit          typed;
    out_item_t   result;
  } sprite_row_t;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // exact integer projection; SV division truncates toward zero like the spec
  function automatic out_item_t project_sprite(in_item_t s);
    out_item_t r;
    longint sx, sy, dx, dy, px, py, det, n, m, hc;
    longint front, dep, cen, sz, half;
    sx = longint'(s.sprite_pos_x) - longint'(cam_pos_x);
    sy = longint'(s.sprite_pos_y) - longint'(cam_pos_y);
    dx = longint'($signed(cam_dir_x));
    dy = longint'($signed(cam_dir_y));
    px = longint'($signed(cam_plane_x));
    py = longint'($signed(cam_plane_y));
    det = px * dy - dx * py;
    n = dy * sx - dx * sy;
    m = -py * sx + px * sy;
    hc = SCREEN_COLUMNS / 2;
    front = 0;
    dep = 0;
    cen = hc;
    sz = 0;
    if (det != 0) begin
      if (m != 0) begin
        front = ((m < 0) == (det < 0)) ? 1 : 0;
        dep = clip((m * 16384) / det, -32768, 32767);
        cen = clip((hc * (m + n)) / m, -32768, 32767);
        sz = (longint'(SCREEN_ROWS) * magnitude(det)) / (magnitude(m) * 64);
        if (sz > 4095) sz = 4095;
      end else begin
        // zero depth: size saturates, centre goes to the side of n
        sz = 4095;
        cen = n > 0 ? 32767 : (n < 0 ? -32768 : hc);
      end
    end
    half = sz / 2;
    r.in_front      = front[0];
    r.depth         = dep[15:0];
    r.centre_column = cen[15:0];
    r.sprite_size   = sz[11:0];
    r.first_column  = 10'(clip(cen - half, 0, SCREEN_COLUMNS - 1));
    r.last_column   = 10'(clip(cen + half, 0, SCREEN_COLUMNS - 1));
    r.first_row     = 9'(clip(SCREEN_ROWS / 2 - half, 0, SCREEN_ROWS - 1));
    r.last_row      = 9'(clip(SCREEN_ROWS / 2 + half, 0, SCREEN_ROWS - 1));
    r.texture_out   = s.sprite_texture;
    return r;
  endfunction

  // monitor both queue ends and the config channel on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_x   <= 16'd0;
      cam_pos_y   <= 16'd0;
      cam_dir_x   <= 16'hC000;
      cam_dir_y   <= 16'd0;
      cam_plane_x <= 16'd0;
      cam_plane_y <= 16'd10813;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgPlayerPosX:   cam_pos_x   <= cfg_data_i;
          CfgPlayerPosY:   cam_pos_y   <= cfg_data_i;
          CfgViewDirX:     cam_dir_x   <= cfg_data_i;
          CfgViewDirY:     cam_dir_y   <= cfg_data_i;
          CfgCameraPlaneX: cam_plane_x <= cfg_data_i;
          CfgCameraPlaneY: cam_plane_y <= cfg_data_i;
          default: ;
        endcase
      end
      // result transfer: compare with the oldest projection
      if (pop && !empty) begin
        if (projections_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          if (out_data_o !== projections_due[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p actual %p", projections_due[0], out_data_o);
          end
          void'(projections_due.pop_front());
        end
      end
      // sprite transfer: predict now, config is stable while sprites are in flight
      if (push && !full) projections_due.push_back(project_sprite(in_data_i));
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 11);
  endfunction

  // push stays high across back-to-back sprites
  task automatic send_sprite(in_item_t s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // only reconfigure once every projection is back and the pipe is quiet
  task automatic drain();
    push <= 1'b0;
    while (projections_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_camera(logic [15:0] ppx, logic [15:0] ppy, logic [15:0] dx,
                            logic [15:0] dy, logic [15:0] qx, logic [15:0] qy);
    drain();
    write_reg(CfgPlayerPosX, ppx);
    write_reg(CfgPlayerPosY, ppy);
    write_reg(CfgViewDirX, dx);
    write_reg(CfgViewDirY, dy);
    write_reg(CfgCameraPlaneX, qx);
    write_reg(CfgCameraPlaneY, qy);
  endtask

  // random sprite, mostly near the player so the projection lands on screen
  function automatic in_item_t random_sprite();
    in_item_t s;
    s.sprite_texture = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) begin
      s.sprite_pos_x = 16'($urandom);
      s.sprite_pos_y = 16'($urandom);
    end else begin
      s.sprite_pos_x = cam_pos_x + 16'($urandom_range(0, 4095)) - 16'd2048;
      s.sprite_pos_y = cam_pos_y + 16'($urandom_range(0, 4095)) - 16'd2048;
    end
    return s;
  endfunction

  // result pops with random stalls
  initial begin
    int stall;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sprite_row_t rows[$];
    sprite_row_t row;
    out_item_t   origin;
    logic [15:0] q;

    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgPlayerPosX;
    cfg_data_i  <= '0;
    mismatches  = 0;
    no_idle     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sprite on the player under the reset camera: zero depth, full-screen square
    origin = '{in_front: 1'b0, depth: 16'sd0, centre_column: 16'sd320, sprite_size: 12'd4095,
               first_column: 10'd0, last_column: 10'd639, first_row: 9'd0,
               last_row: 9'd479, texture_out: 3'd5};
    rows.push_back('{16'd0, 16'd0, '{16'd0, 16'd0, 3'd5}, 1'b1, origin});
    rows.push_back('{16'd0, 16'd0, '{16'hFFFF, 16'hFFFF, 3'd7}, 1'b0, '0});
    rows.push_back('{16'd0, 16'd0, '{16'hFFFF, 16'd0, 3'd0}, 1'b0, '0});   // behind camera
    rows.push_back('{16'd0, 16'd0, '{16'd0, 16'hFFFF, 3'd1}, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'hFFFF, '{16'd0, 16'd0, 3'd2}, 1'b0, '0}); // in front, far
    rows.push_back('{16'h8000, 16'h8000, '{16'h7F00, 16'h8000, 3'd3}, 1'b0, '0}); // in front
    rows.push_back('{16'h8000, 16'h8000, '{16'h7FFF, 16'h8000, 3'd4}, 1'b0, '0}); // very close
    rows.push_back('{16'h8000, 16'h8000, '{16'h7000, 16'h8400, 3'd6}, 1'b0, '0});
    rows.push_back('{16'h8000, 16'h8000, '{16'h7000, 16'h7C00, 3'd6}, 1'b0, '0});
    rows.push_back('{16'h8000, 16'h8000, '{16'h7F00, 16'h0000, 3'd1}, 1'b0, '0}); // off left
    rows.push_back('{16'h8000, 16'h8000, '{16'h7F00, 16'hFFFF, 3'd2}, 1'b0, '0}); // off right
    rows.push_back('{16'h8000, 16'h8000, '{16'h8000, 16'h9000, 3'd0}, 1'b0, '0}); // zero depth
    rows.push_back('{16'h8000, 16'h8000, '{16'h8000, 16'h7000, 3'd7}, 1'b0, '0}); // other side
    rows.push_back('{16'h8000, 16'h8000, '{16'h8000, 16'h8000, 3'd5}, 1'b0, '0}); // on player

    foreach (rows[i]) begin
      row = rows[i];
      if (row.player_x != cam_pos_x || row.player_y != cam_pos_y) begin
        drain();
        write_reg(CfgPlayerPosX, row.player_x);
        write_reg(CfgPlayerPosY, row.player_y);
      end
      send_sprite(row.sprite);
      // typed rows also check the predictor itself
      if (row.typed && project_sprite(row.sprite) !== row.result) begin
        mismatches++;
        if (mismatches <= 10)
          $display("typed row %0d: expected %p predicted %p", i, row.result,
                   project_sprite(row.sprite));
      end
    end

    // camera phases: extremes, singular camera, a fixed camera, then random cameras
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_camera(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        1: set_camera(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        2: set_camera(16'h8000, 16'h8000, 16'h0000, 16'h4000, 16'h0000, 16'h0000); // singular
        3: set_camera(16'h4000, 16'hC000, 16'h0000, 16'h4000, 16'hD5C3, 16'h0000);
        default: begin
          q = 16'($urandom);
          set_camera(16'($urandom), 16'($urandom), q, 16'($urandom_range(0, 65535)),
                     16'($urandom), 16'($urandom) ^ q);
        end
      endcase
      for (int k = 0; k < 190; k++) begin
        if (k % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
        send_sprite(random_sprite());
      end
      no_idle = 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
